// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLY(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

// ===== rtl/core/mfne_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfne_pkg
// Shared types and constants of the midi file note extractor.
// ----------------------------------------------------------------------------
package mfne_pkg;

    localparam int unsigned TABLE_ADDR_BITS = 11;
    localparam int unsigned TABLE_DEPTH     = 1 << TABLE_ADDR_BITS;
    localparam int unsigned PROD_BITS       = 44;   // sample_rate * us_per_quarter
    localparam int unsigned DIV_BITS        = 36;   // 1e6 * ticks_per_quarter
    localparam int unsigned US_PER_SEC      = 1000000;
    localparam int unsigned SR_BITS         = 20;

    localparam logic [SR_BITS-1:0] SAMPLE_RATE_RESET = 20'd44100;
    localparam logic               CFG_SAMPLE_RATE   = 1'b0;

    typedef enum logic [1:0] {
        RK_NOTE  = 2'd0,
        RK_ERROR = 2'd1,
        RK_DONE  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        EC_BAD_TAG    = 3'd0,
        EC_NO_TRACKS  = 3'd1,
        EC_NO_STATUS  = 3'd2,
        EC_BAD_BYTE   = 3'd3,
        EC_PREMATURE  = 3'd4,
        EC_NONE       = 3'd5
    } t_err;

    typedef struct packed {
        logic                       restart;
        logic                       latch_in;
        logic                       mem_rd;
        logic                       commit;
        logic                       clr_en;
        logic [TABLE_ADDR_BITS-1:0] clr_addr;
        logic                       conv_start;
        logic                       conv_sel;
        logic                       out_load;
    } t_cmd;

    typedef struct packed {
        logic has_result;
        logic is_note;
        logic conv_done;
    } t_status;

endpackage

`default_nettype wire

// ===== rtl/core/mfne_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfne_in_if
// File byte channel: one beat per byte of the file.
// ----------------------------------------------------------------------------
interface mfne_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, output file_byte, output first_byte, output last_byte,
                    input ready);
    modport sink (input valid, input file_byte, input first_byte, input last_byte,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mfne_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfne_out_if
// Result channel: notes, errors and the finished marker.
// ----------------------------------------------------------------------------
interface mfne_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] start_samples;
    logic [31:0] length_samples;
    logic [6:0]  note_key;
    logic [3:0]  note_channel;
    logic [2:0]  error_code;

    modport source (output valid, output result_kind, output start_samples,
                    output length_samples, output note_key, output note_channel,
                    output error_code, input ready);
    modport sink (input valid, input result_kind, input start_samples,
                  input length_samples, input note_key, input note_channel,
                  input error_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/midi_file_note_extractor_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// midi_file_note_extractor_unit
// Parses a standard midi file byte stream and emits paired notes in samples.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        payload
//  i_in      in   valid/ready      file_byte, first_byte, last_byte
//  o_out     out  valid/ready      result_kind, start/length_samples, key, channel, code
//  apb       in   psel/penable     sample_rate at address 0
//
//  a byte is accepted in the idle state, then passes a table read and the parse commit
//  a closed note adds two conversions in the conversion unit, each passing start,
//  serial multiply, restoring divide and done
//  after reset, and on every first_byte, a clearing pass over all 2048 entries wipes the table
//  a result waits in the output register; the next byte is accepted meanwhile, but a
//  further result stalls until the output beat is taken
// ----------------------------------------------------------------------------
module midi_file_note_extractor_unit #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mfne_in_if.sink          i_in,
    mfne_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import mfne_pkg::*;

    logic [SR_BITS-1:0] r_sample_rate;
    t_cmd               cmd;
    t_status            sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SAMPLE_RATE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == CFG_SAMPLE_RATE) begin
            r_sample_rate <= pwdata[SR_BITS-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_SAMPLE_RATE) ? {12'd0, r_sample_rate} : 32'd0;

    mfne_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_first_byte (i_in.first_byte),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    mfne_datapath #(
        .TICK_BITS (TICK_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_file_byte      (i_in.file_byte),
        .i_last_byte      (i_in.last_byte),
        .i_sample_rate    (r_sample_rate),
        .o_result_kind    (o_out.result_kind),
        .o_start_samples  (o_out.start_samples),
        .o_length_samples (o_out.length_samples),
        .o_note_key       (o_out.note_key),
        .o_note_channel   (o_out.note_channel),
        .o_error_code     (o_out.error_code)
    );

endmodule

`default_nettype wire

// ===== rtl/core/mfne_conv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfne_conv
// Ticks to samples: serial shift-add multiply, then restoring divide,
// quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
module mfne_conv #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [TICK_BITS-1:0]            i_ticks,
    input  wire logic [mfne_pkg::SR_BITS-1:0]    i_sample_rate,
    input  wire logic [23:0]                     i_us_per_quarter,
    input  wire logic [15:0]                     i_ticks_per_quarter,
    output logic                                 o_done,
    output logic [31:0]                          o_samples
);
    import mfne_pkg::*;

    localparam int unsigned NW = TICK_BITS + PROD_BITS;
    localparam int unsigned CW = $clog2(NW);

    logic [PROD_BITS-1:0] r_p;
    logic [DIV_BITS-1:0]  r_d;
    logic [TICK_BITS-1:0] r_t;
    logic [NW-1:0]        r_acc;
    logic [DIV_BITS-1:0]  r_r;
    logic [32:0]          r_q;
    logic                 r_big;
    logic [CW-1:0]        r_cnt;
    logic                 r_mul;
    logic                 r_div;
    logic                 r_done;

    logic [15:0]         tpq_nz;
    logic [DIV_BITS:0]   rem2;
    logic                ge;
    logic [DIV_BITS:0]   rem_n;
    logic [32:0]         n_q;

    always_comb begin
        tpq_nz = (i_ticks_per_quarter == 16'd0) ? 16'd1 : i_ticks_per_quarter;
        rem2   = {r_r, r_acc[NW-1]};
        ge     = rem2 >= {1'b0, r_d};
        rem_n  = ge ? rem2 - {1'b0, r_d} : rem2;
        n_q    = {r_q[31:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_div  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_p   <= {24'd0, i_sample_rate} * {20'd0, i_us_per_quarter};
                r_d   <= DIV_BITS'(US_PER_SEC) * {20'd0, tpq_nz};
                r_t   <= i_ticks;
                r_acc <= '0;
                r_r   <= '0;
                r_q   <= '0;
                r_big <= 1'b0;
                r_cnt <= CW'(TICK_BITS - 1);
                r_mul <= 1'b1;
            end else if (r_mul) begin
                r_acc <= {r_acc[NW-2:0], 1'b0} + (r_t[TICK_BITS-1] ? NW'(r_p) : NW'(0));
                r_t   <= {r_t[TICK_BITS-2:0], 1'b0};
                if (r_cnt == '0) begin
                    r_mul <= 1'b0;
                    r_div <= 1'b1;
                    r_cnt <= CW'(NW - 1);
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (r_div) begin
                r_r   <= rem_n[DIV_BITS-1:0];
                r_acc <= {r_acc[NW-2:0], 1'b0};
                r_q   <= n_q;
                r_big <= r_big | n_q[32];
                if (r_cnt == '0) begin
                    r_div  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_samples = r_big ? 32'hFFFF_FFFF : r_q[31:0];

endmodule

`default_nettype wire

// ===== rtl/core/mfne_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfne_datapath
// Parse registers, note start table, conversion unit and result registers.
// ----------------------------------------------------------------------------
module mfne_datapath #(
    parameter int unsigned TICK_BITS = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire mfne_pkg::t_cmd               i_cmd,
    output mfne_pkg::t_status                 o_sts,
    input  wire logic [7:0]                   i_file_byte,
    input  wire logic                         i_last_byte,
    input  wire logic [mfne_pkg::SR_BITS-1:0] i_sample_rate,
    output logic [1:0]                        o_result_kind,
    output logic [31:0]                       o_start_samples,
    output logic [31:0]                       o_length_samples,
    output logic [6:0]                        o_note_key,
    output logic [3:0]                        o_note_channel,
    output logic [2:0]                        o_error_code
);
    import mfne_pkg::*;

    localparam int unsigned AW = (TICK_BITS > 32) ? TICK_BITS : 32;
    localparam logic [31:0] TAG_HEADER = 32'h4D54_6864;
    localparam logic [31:0] TAG_TRACK  = 32'h4D54_726B;

    typedef enum logic [4:0] {
        PH_HDR_TAG, PH_HDR_LEN, PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV, PH_HDR_FLUSH,
        PH_TRK_TAG, PH_TRK_LEN, PH_EV_DELTA, PH_EV_STATUS, PH_EV_DATA1, PH_EV_DATA2,
        PH_META_TYPE, PH_META_LEN, PH_META_BODY, PH_SYSEX_LEN, PH_SKIP, PH_DONE
    } t_phase;

    function automatic logic [1:0] data_bytes(input logic [7:0] st);
        logic [1:0] n;
        n = 2'd0;
        case (st[7:4]) inside
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: n = 2'd2;
            4'hC, 4'hD:                   n = 2'd1;
            default:                      n = 2'd0;
        endcase
        return n;
    endfunction

    // parse state
    t_phase               r_phase, n_phase;
    logic [TICK_BITS-1:0] r_tick, n_tick;
    logic [7:0]           r_rs, n_rs;
    logic [31:0]          r_cbl, n_cbl;
    logic [31:0]          r_fa, n_fa;
    logic [2:0]           r_fbs, n_fbs;
    logic [7:0]           r_fdv, n_fdv;
    logic [15:0]          r_ntrk, n_ntrk;
    logic [15:0]          r_tdone, n_tdone;
    logic [15:0]          r_tpq, n_tpq;
    logic [23:0]          r_us, n_us;
    logic [7:0]           r_meta, n_meta;
    logic                 r_errl, n_errl;
    logic [23:0]          r_tempo, n_tempo;

    logic [7:0]           r_byte;
    logic                 r_last;

    // note start table: valid bit over start tick
    logic [TICK_BITS:0]   r_table [TABLE_DEPTH];
    logic [TICK_BITS:0]   r_rd;

    // pending result
    t_kind                r_pk_kind;
    t_err                 r_pk_err;
    logic [6:0]           r_pk_key;
    logic [3:0]           r_pk_ch;
    logic [TICK_BITS-1:0] r_st_ticks;
    logic [TICK_BITS-1:0] r_ln_ticks;
    logic [31:0]          r_st_samp;
    logic [31:0]          r_ln_samp;

    // comb parse outputs
    logic                       run, err_v, done_v, note_v, ev_end, trk_end, hdr_end;
    t_err                       err_c;
    logic                       mem_we;
    logic [TICK_BITS:0]         mem_wd;
    logic [TABLE_ADDR_BITS-1:0] slot;
    logic [31:0]                acc32;
    logic [15:0]                acc16;
    logic [AW-1:0]              tsum;
    logic [1:0]                 need;
    logic                       conv_done;
    logic [31:0]                conv_q;

    assign slot = {r_rs[3:0], r_fdv[6:0]};

    always_comb begin
        n_phase = r_phase;  n_tick = r_tick;   n_rs = r_rs;     n_cbl = r_cbl;
        n_fa = r_fa;        n_fbs = r_fbs;     n_fdv = r_fdv;   n_ntrk = r_ntrk;
        n_tdone = r_tdone;  n_tpq = r_tpq;     n_us = r_us;     n_meta = r_meta;
        n_errl = r_errl;    n_tempo = r_tempo;
        err_v = 1'b0;  err_c = EC_NONE;  done_v = 1'b0;  note_v = 1'b0;
        ev_end = 1'b0; trk_end = 1'b0;   hdr_end = 1'b0;
        mem_we = 1'b0; mem_wd = '0;
        acc32 = {r_fa[23:0], r_byte};
        acc16 = {r_fa[7:0], r_byte};
        tsum  = '0;
        need  = data_bytes(r_rs);
        run   = !(r_errl || r_phase == PH_DONE);

        if (run) begin
            if (r_phase != PH_HDR_TAG && r_phase != PH_HDR_LEN && r_phase != PH_TRK_TAG
                && r_phase != PH_TRK_LEN && r_cbl != 32'd0) begin
                n_cbl = r_cbl - 32'd1;
            end

            unique case (r_phase) inside
                PH_HDR_TAG, PH_TRK_TAG: begin
                    n_fa  = acc32;
                    n_fbs = r_fbs + 3'd1;
                    if (r_fbs == 3'd3) begin
                        if (acc32 != ((r_phase == PH_HDR_TAG) ? TAG_HEADER : TAG_TRACK)) begin
                            err_v = 1'b1;
                            err_c = EC_BAD_TAG;
                        end else begin
                            n_phase = (r_phase == PH_HDR_TAG) ? PH_HDR_LEN : PH_TRK_LEN;
                            n_fa    = '0;
                            n_fbs   = '0;
                        end
                    end
                end
                PH_HDR_LEN, PH_TRK_LEN: begin
                    n_fa  = acc32;
                    n_fbs = r_fbs + 3'd1;
                    if (r_fbs == 3'd3) begin
                        n_cbl = acc32;
                        n_fa  = '0;
                        n_fbs = '0;
                        if (r_phase == PH_HDR_LEN) begin
                            n_phase = PH_HDR_FMT;
                        end else begin
                            n_tick = '0;
                            n_rs   = '0;
                            if (acc32 == 32'd0) ev_end = 1'b1;
                            else                n_phase = PH_EV_DELTA;
                        end
                    end
                end
                PH_HDR_FMT, PH_HDR_NTRK, PH_HDR_DIV: begin
                    n_fa  = {16'd0, acc16};
                    n_fbs = r_fbs + 3'd1;
                    if (r_fbs == 3'd1) begin
                        n_fa  = '0;
                        n_fbs = '0;
                        if (r_phase == PH_HDR_FMT) begin
                            n_phase = PH_HDR_NTRK;
                        end else if (r_phase == PH_HDR_NTRK) begin
                            n_ntrk  = acc16;
                            n_phase = PH_HDR_DIV;
                        end else begin
                            n_tpq = acc16;
                            if (n_cbl != 32'd0) n_phase = PH_HDR_FLUSH;
                            else                hdr_end = 1'b1;
                        end
                    end
                end
                PH_HDR_FLUSH: begin
                    if (n_cbl == 32'd0) hdr_end = 1'b1;
                end
                PH_EV_DELTA, PH_META_LEN, PH_SYSEX_LEN: begin
                    n_fa = {r_fa[24:0], r_byte[6:0]};
                    if (!r_byte[7]) begin
                        if (r_phase == PH_EV_DELTA) begin
                            tsum    = AW'(r_tick) + AW'(n_fa);
                            n_tick  = tsum[TICK_BITS-1:0];
                            n_fa    = '0;
                            n_phase = PH_EV_STATUS;
                        end else begin
                            n_fbs   = '0;
                            n_tempo = '0;
                            if (n_fa == 32'd0) ev_end = 1'b1;
                            else n_phase = (r_phase == PH_META_LEN) ? PH_META_BODY : PH_SKIP;
                        end
                    end
                end
                PH_EV_STATUS: begin
                    if (!r_byte[7]) begin
                        if (r_rs == 8'd0) begin
                            err_v = 1'b1;
                            err_c = EC_NO_STATUS;
                        end else if (need == 2'd0) begin
                            err_v = 1'b1;
                            err_c = EC_BAD_BYTE;
                        end else begin
                            n_fdv = r_byte;
                            if (need == 2'd1) ev_end = 1'b1;
                            else              n_phase = PH_EV_DATA2;
                        end
                    end else begin
                        n_rs = r_byte;
                        if (data_bytes(r_byte) != 2'd0) begin
                            n_phase = PH_EV_DATA1;
                        end else if (r_byte == 8'hFF) begin
                            n_phase = PH_META_TYPE;
                        end else if (r_byte == 8'hF0 || r_byte == 8'hF7) begin
                            n_fa    = '0;
                            n_phase = PH_SYSEX_LEN;
                        end else begin
                            err_v = 1'b1;
                            err_c = EC_BAD_BYTE;
                        end
                    end
                end
                PH_EV_DATA1: begin
                    n_fdv = r_byte;
                    if (need == 2'd1) ev_end = 1'b1;
                    else              n_phase = PH_EV_DATA2;
                end
                PH_EV_DATA2: begin
                    if (r_rs[7:4] == 4'h9 && r_byte != 8'd0) begin
                        if (!r_rd[TICK_BITS]) begin
                            mem_we = 1'b1;
                            mem_wd = {1'b1, r_tick};
                        end
                    end else if ((r_rs[7:4] == 4'h8 || r_rs[7:4] == 4'h9) && r_rd[TICK_BITS]) begin
                        note_v = 1'b1;
                        mem_we = 1'b1;
                        mem_wd = '0;
                    end
                    ev_end = 1'b1;
                end
                PH_META_TYPE: begin
                    n_meta  = r_byte;
                    n_fa    = '0;
                    n_phase = PH_META_LEN;
                end
                PH_META_BODY: begin
                    if (r_meta == 8'h51 && r_fbs < 3'd3) begin
                        n_tempo = {r_tempo[15:0], r_byte};
                        n_fbs   = r_fbs + 3'd1;
                    end
                    n_fa = r_fa - 32'd1;
                    if (n_fa == 32'd0) begin
                        if (r_meta == 8'h51 && n_fbs == 3'd3) n_us = n_tempo;
                        ev_end = 1'b1;
                    end
                end
                PH_SKIP: begin
                    n_fa = r_fa - 32'd1;
                    if (n_fa == 32'd0) ev_end = 1'b1;
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            if (hdr_end) begin
                if (r_ntrk == 16'd0) begin
                    err_v = 1'b1;
                    err_c = EC_NO_TRACKS;
                end else begin
                    n_phase = PH_TRK_TAG;
                    n_fa    = '0;
                    n_fbs   = '0;
                end
            end

            if (ev_end) begin
                n_fa  = '0;
                n_fbs = '0;
                if (n_cbl == 32'd0) trk_end = 1'b1;
                else                n_phase = PH_EV_DELTA;
            end

            if (trk_end) begin
                n_tdone = r_tdone + 16'd1;
                if (n_tdone >= r_ntrk) begin
                    n_phase = PH_DONE;
                    done_v  = 1'b1;
                end else begin
                    n_phase = PH_TRK_TAG;
                end
            end

            if (!err_v && r_last && n_phase != PH_DONE) begin
                err_v = 1'b1;
                err_c = EC_PREMATURE;
            end
            if (err_v) n_errl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_phase <= PH_HDR_TAG;  r_tick <= '0;   r_rs <= '0;      r_cbl <= '0;
            r_fa <= '0;             r_fbs <= '0;    r_fdv <= '0;     r_ntrk <= '0;
            r_tdone <= '0;          r_tpq <= 16'd480;
            r_us <= 24'd500000;     r_meta <= '0;   r_errl <= 1'b0;  r_tempo <= '0;
        end else if (i_cmd.commit) begin
            r_phase <= n_phase;     r_tick <= n_tick; r_rs <= n_rs;  r_cbl <= n_cbl;
            r_fa <= n_fa;           r_fbs <= n_fbs; r_fdv <= n_fdv;  r_ntrk <= n_ntrk;
            r_tdone <= n_tdone;     r_tpq <= n_tpq;
            r_us <= n_us;           r_meta <= n_meta; r_errl <= n_errl; r_tempo <= n_tempo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_byte <= i_file_byte;
            r_last <= i_last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_table[i_cmd.clr_addr] <= '0;
        end else if (i_cmd.commit && run && mem_we) begin
            r_table[slot] <= mem_wd;
        end
        if (i_cmd.mem_rd) begin
            r_rd <= r_table[slot];
        end
    end

    // pending result, latched with the parse commit; sample values latched when a conversion is done
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_pk_kind  <= err_v ? RK_ERROR : (done_v ? RK_DONE : RK_NOTE);
            r_pk_err   <= err_v ? err_c : EC_NONE;
            r_pk_key   <= r_fdv[6:0];
            r_pk_ch    <= r_rs[3:0];
            r_st_ticks <= r_rd[TICK_BITS-1:0];
            r_ln_ticks <= r_tick - r_rd[TICK_BITS-1:0];
        end
        if (conv_done) begin
            if (i_cmd.conv_sel) r_ln_samp <= conv_q;
            else                r_st_samp <= conv_q;
        end
    end

    mfne_conv #(
        .TICK_BITS (TICK_BITS)
    ) u_conv (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (i_cmd.conv_start),
        .i_ticks             (i_cmd.conv_sel ? r_ln_ticks : r_st_ticks),
        .i_sample_rate       (i_sample_rate),
        .i_us_per_quarter    (r_us),
        .i_ticks_per_quarter (r_tpq),
        .o_done              (conv_done),
        .o_samples           (conv_q)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_result_kind    <= r_pk_kind;
            o_error_code     <= r_pk_err;
            o_start_samples  <= (r_pk_kind == RK_NOTE) ? r_st_samp : 32'd0;
            o_length_samples <= (r_pk_kind == RK_NOTE) ? r_ln_samp : 32'd0;
            o_note_key       <= (r_pk_kind == RK_NOTE) ? r_pk_key : 7'd0;
            o_note_channel   <= (r_pk_kind == RK_NOTE) ? r_pk_ch : 4'd0;
        end
    end

    always_comb begin
        o_sts.has_result = run && (err_v || done_v || note_v);
        o_sts.is_note    = !err_v && !done_v && note_v;
        o_sts.conv_done  = conv_done;
    end

endmodule

`default_nettype wire

// ===== rtl/core/mfne_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// mfne_ctrl
// Sequencer: table clearing sweep, byte read/execute, the two
// conversions of a note and the output register handshake.
// ----------------------------------------------------------------------------
module mfne_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_first_byte,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output mfne_pkg::t_cmd          o_cmd,
    input  wire mfne_pkg::t_status  i_sts
);
    import mfne_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_CONV0, S_WAIT0, S_CONV1, S_WAIT1, S_PUSH
    } t_state;

    t_state                     r_state;
    logic [TABLE_ADDR_BITS-1:0] r_clr_addr;
    logic                       r_clr_item;
    logic                       r_out_valid;
    logic                       load;

    assign load = (r_state == S_PUSH) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load)             r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) r_state <= r_clr_item ? S_READ : S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_clr_item <= i_first_byte;
                        r_clr_addr <= '0;
                        r_state    <= i_first_byte ? S_CLEAR : S_READ;
                    end
                end
                S_READ: r_state <= S_EXEC;
                S_EXEC: begin
                    if (!i_sts.has_result)  r_state <= S_IDLE;
                    else if (i_sts.is_note) r_state <= S_CONV0;
                    else                    r_state <= S_PUSH;
                end
                S_CONV0: r_state <= S_WAIT0;
                S_WAIT0: if (i_sts.conv_done) r_state <= S_CONV1;
                S_CONV1: r_state <= S_WAIT1;
                S_WAIT1: if (i_sts.conv_done) r_state <= S_PUSH;
                S_PUSH:  if (load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.restart    = (r_state == S_IDLE) && i_in_valid && i_first_byte;
        o_cmd.latch_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mem_rd     = (r_state == S_READ);
        o_cmd.commit     = (r_state == S_EXEC);
        o_cmd.clr_en     = (r_state == S_CLEAR);
        o_cmd.clr_addr   = r_clr_addr;
        o_cmd.conv_start = (r_state == S_CONV0) || (r_state == S_CONV1);
        o_cmd.conv_sel   = (r_state == S_CONV1) || (r_state == S_WAIT1);
        o_cmd.out_load   = load;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `ASSERT_IMPLY(a_exec_after_read, i_clk, i_rst_n, r_state == S_EXEC, $past(r_state) == S_READ, "execute without table read")
    `ASSERT_IMPLY(a_conv_done_waiting, i_clk, i_rst_n, i_sts.conv_done, r_state == S_WAIT0 || r_state == S_WAIT1, "conversion done outside wait")
    `ASSERT_NEXT(a_load_sets_valid, i_clk, i_rst_n, load, r_out_valid, "loaded result not presented")

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Midi file note extractor testbench. Streams whole and broken midi files into
// the block and compares every note, error and finished beat with a cycle-free
// parse model of its own.
// ----------------------------------------------------------------------------
module tb_top;
    import mfne_pkg::*;

    localparam int LIMIT_CYCLES = 15000000;
    localparam int SETTLE       = 2600;     // table clear plus two conversions

    typedef enum int {
        P_HDR_TAG, P_HDR_LEN, P_HDR_FMT, P_HDR_NTRK, P_HDR_DIV, P_HDR_FLUSH,
        P_TRK_TAG, P_TRK_LEN, P_EV_DELTA, P_EV_STATUS, P_EV_DATA1, P_EV_DATA2,
        P_META_TYPE, P_META_LEN, P_META_BODY, P_SYSEX_LEN, P_SKIP, P_DONE
    } t_phase;

    typedef struct {
        t_kind       kind;
        logic [31:0] start;
        logic [31:0] len;
        logic [6:0]  key;
        logic [3:0]  chan;
        t_err        code;
    } t_note_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    mfne_in_if  in_ch();
    mfne_out_if out_ch();

    midi_file_note_extractor_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 i_clk = ~i_clk;

    // parse model state
    logic [19:0] sample_rate;
    bit          slot_open [2048];
    logic [31:0] slot_tick [2048];
    logic [31:0] cur_tick, chunk_left, field_acc;
    logic [7:0]  run_status, data1, meta_kind;
    int          field_cnt;
    t_phase      phase;
    logic [15:0] trk_declared, trk_done, tick_div;
    logic [23:0] tempo, tempo_acc;
    bit          err_held;

    t_note_result expected_results[$];
    int          errors = 0;
    int          bytes_sent = 0;
    int          src_idle = 0, snk_idle = 0;
    int          hold_cycles = 0;
    longint      cycles = 0;

    logic [7:0]  file_bytes[$];
    logic [7:0]  trk_bytes[$];

    // ---------------- parse model ----------------
    function automatic void restart_parse();
        for (int i = 0; i < 2048; i++) begin
            slot_open[i] = 0;
            slot_tick[i] = '0;
        end
        cur_tick = '0; run_status = '0; phase = P_HDR_TAG; chunk_left = '0;
        field_acc = '0; field_cnt = 0; data1 = '0; trk_declared = '0; trk_done = '0;
        tick_div = 16'd480; tempo = 24'd500000; meta_kind = '0; err_held = 0;
        tempo_acc = '0;
    endfunction

    function automatic logic [31:0] ticks_to_samples(logic [31:0] ticks);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        num = 128'(ticks) * (128'(sample_rate) * 128'(tempo));
        den = 128'(1000000) * 128'((tick_div != 0) ? tick_div : 16'd1);
        q = num / den;
        return (q > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function automatic int data_count(logic [7:0] st);
        case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: return 2;
            4'hC, 4'hD: return 1;
            default: return 0;
        endcase
    endfunction

    function automatic bit close_track();
        trk_done = trk_done + 16'd1;
        field_acc = '0; field_cnt = 0;
        if (trk_done >= trk_declared) begin
            phase = P_DONE;
            return 1;
        end
        phase = P_TRK_TAG;
        return 0;
    endfunction

    function automatic bit close_event();
        field_acc = '0; field_cnt = 0;
        if (chunk_left == 0) return close_track();
        phase = P_EV_DELTA;
        return 0;
    endfunction

    function automatic int close_header();
        if (trk_declared == 0) return int'(EC_NO_TRACKS);
        phase = P_TRK_TAG;
        field_acc = '0; field_cnt = 0;
        return -1;
    endfunction

    function automatic void parse_byte(logic [7:0] c, bit first, bit last);
        int err;
        bit done, note, hdr;
        logic [10:0] slot;
        logic [3:0] kind;
        logic [15:0] v;
        t_note_result r;
        err = -1; done = 0; note = 0;
        r = '{RK_NOTE, '0, '0, '0, '0, EC_NONE};
        if (first) restart_parse();
        if (err_held || phase == P_DONE) return;
        if (phase != P_HDR_TAG && phase != P_HDR_LEN && phase != P_TRK_TAG &&
            phase != P_TRK_LEN && chunk_left != 0)
            chunk_left = chunk_left - 1;
        case (phase)
            P_HDR_TAG, P_TRK_TAG: begin
                field_acc = {field_acc[23:0], c};
                field_cnt++;
                if (field_cnt == 4) begin
                    hdr = (phase == P_HDR_TAG);
                    if (field_acc != (hdr ? 32'h4D546864 : 32'h4D54726B)) begin
                        err = int'(EC_BAD_TAG);
                    end else begin
                        phase = hdr ? P_HDR_LEN : P_TRK_LEN;
                        field_acc = '0; field_cnt = 0;
                    end
                end
            end
            P_HDR_LEN, P_TRK_LEN: begin
                field_acc = {field_acc[23:0], c};
                field_cnt++;
                if (field_cnt == 4) begin
                    chunk_left = field_acc;
                    field_acc = '0; field_cnt = 0;
                    if (phase == P_HDR_LEN) begin
                        phase = P_HDR_FMT;
                    end else begin
                        cur_tick = '0; run_status = '0;
                        if (chunk_left == 0) done = close_track();
                        else phase = P_EV_DELTA;
                    end
                end
            end
            P_HDR_FMT, P_HDR_NTRK, P_HDR_DIV: begin
                field_acc = {16'h0, field_acc[7:0], c};
                field_cnt++;
                if (field_cnt == 2) begin
                    v = field_acc[15:0];
                    field_acc = '0; field_cnt = 0;
                    if (phase == P_HDR_FMT) begin
                        phase = P_HDR_NTRK;
                    end else if (phase == P_HDR_NTRK) begin
                        trk_declared = v;
                        phase = P_HDR_DIV;
                    end else begin
                        tick_div = v;
                        if (chunk_left != 0) phase = P_HDR_FLUSH;
                        else err = close_header();
                    end
                end
            end
            P_HDR_FLUSH: begin
                if (chunk_left == 0) err = close_header();
            end
            P_EV_DELTA, P_META_LEN, P_SYSEX_LEN: begin
                field_acc = {field_acc[24:0], c[6:0]};
                if (!c[7]) begin
                    if (phase == P_EV_DELTA) begin
                        cur_tick = cur_tick + field_acc;
                        field_acc = '0;
                        phase = P_EV_STATUS;
                    end else begin
                        field_cnt = 0; tempo_acc = '0;
                        if (field_acc == 0) done = close_event();
                        else phase = (phase == P_META_LEN) ? P_META_BODY : P_SKIP;
                    end
                end
            end
            P_EV_STATUS: begin
                if (!c[7]) begin
                    if (run_status == 0) err = int'(EC_NO_STATUS);
                    else if (data_count(run_status) == 0) err = int'(EC_BAD_BYTE);
                    else begin
                        data1 = c;
                        if (data_count(run_status) == 1) done = close_event();
                        else phase = P_EV_DATA2;
                    end
                end else begin
                    run_status = c;
                    if (data_count(c) != 0) phase = P_EV_DATA1;
                    else if (c == 8'hFF) phase = P_META_TYPE;
                    else if (c == 8'hF0 || c == 8'hF7) begin
                        field_acc = '0;
                        phase = P_SYSEX_LEN;
                    end else err = int'(EC_BAD_BYTE);
                end
            end
            P_EV_DATA1: begin
                data1 = c;
                if (data_count(run_status) == 1) done = close_event();
                else phase = P_EV_DATA2;
            end
            P_EV_DATA2: begin
                kind = run_status[7:4];
                slot = {run_status[3:0], data1[6:0]};
                if (kind == 4'h9 && c != 0) begin
                    if (!slot_open[slot]) begin
                        slot_open[slot] = 1;
                        slot_tick[slot] = cur_tick;
                    end
                end else if ((kind == 4'h8 || kind == 4'h9) && slot_open[slot]) begin
                    note = 1;
                    r.start = ticks_to_samples(slot_tick[slot]);
                    r.len = ticks_to_samples(cur_tick - slot_tick[slot]);
                    r.key = data1[6:0];
                    r.chan = run_status[3:0];
                    slot_open[slot] = 0;
                end
                done = close_event();
            end
            P_META_TYPE: begin
                meta_kind = c; field_acc = '0; phase = P_META_LEN;
            end
            P_META_BODY: begin
                if (meta_kind == 8'h51 && field_cnt < 3) begin
                    tempo_acc = {tempo_acc[15:0], c};
                    field_cnt++;
                end
                field_acc = field_acc - 1;
                if (field_acc == 0) begin
                    if (meta_kind == 8'h51 && field_cnt == 3) tempo = tempo_acc;
                    done = close_event();
                end
            end
            P_SKIP: begin
                field_acc = field_acc - 1;
                if (field_acc == 0) done = close_event();
            end
            default: phase = P_DONE;
        endcase
        if (err < 0 && last && phase != P_DONE) err = int'(EC_PREMATURE);
        if (err >= 0) begin
            err_held = 1;
            expected_results.push_back('{RK_ERROR, '0, '0, '0, '0, t_err'(err)});
        end else if (done) begin
            expected_results.push_back('{RK_DONE, '0, '0, '0, '0, EC_NONE});
        end else if (note) begin
            expected_results.push_back(r);
        end
    endfunction

    // ---------------- result checking ----------------
    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_note_result w;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected beat kind", 32'(out_ch.result_kind), '0);
            end else begin
                w = expected_results.pop_front();
                if (out_ch.result_kind !== w.kind)
                    report_mismatch("result_kind", 32'(out_ch.result_kind), 32'(w.kind));
                if (out_ch.start_samples !== w.start)
                    report_mismatch("start_samples", out_ch.start_samples, w.start);
                if (out_ch.length_samples !== w.len)
                    report_mismatch("length_samples", out_ch.length_samples, w.len);
                if (out_ch.note_key !== w.key)
                    report_mismatch("note_key", 32'(out_ch.note_key), 32'(w.key));
                if (out_ch.note_channel !== w.chan)
                    report_mismatch("note_channel", 32'(out_ch.note_channel), 32'(w.chan));
                if (out_ch.error_code !== w.code)
                    report_mismatch("error_code", 32'(out_ch.error_code), 32'(w.code));
            end
        end
    end

    // receiver hold-off countdown
    always @(posedge i_clk) begin
        if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) out_ch.ready <= 1'b0;
        else out_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
    end

    // ---------------- driving ----------------
    task automatic send_byte(logic [7:0] b, bit first, bit last);
        if ($urandom_range(0, 99) < src_idle) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.file_byte <= b;
        in_ch.first_byte <= first;
        in_ch.last_byte <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        parse_byte(b, first, last);
        bytes_sent++;
    endtask

    task automatic play_file();
        for (int i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == 0, i == file_bytes.size() - 1);
        file_bytes.delete();
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_sample_rate(logic [19:0] rate);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'd0; pwdata <= 32'(rate);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sample_rate = rate;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // ---------------- file building ----------------
    function automatic void put_var(logic [31:0] v);
        logic [7:0] g[$];
        g.push_front({1'b0, v[6:0]});
        v = v >> 7;
        while (v != 0) begin
            g.push_front({1'b1, v[6:0]});
            v = v >> 7;
        end
        foreach (g[i]) trk_bytes.push_back(g[i]);
    endfunction

    function automatic void put32(logic [31:0] v);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_header(logic [15:0] ntrk, logic [15:0] div, int extra);
        put32(32'h4D546864);
        put32(32'(6 + extra));
        file_bytes.push_back(8'h00); file_bytes.push_back(8'h01);
        file_bytes.push_back(ntrk[15:8]); file_bytes.push_back(ntrk[7:0]);
        file_bytes.push_back(div[15:8]); file_bytes.push_back(div[7:0]);
        repeat (extra) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void put_track(logic [31:0] declared);
        put32(32'h4D54726B);
        put32(declared);
        foreach (trk_bytes[i]) file_bytes.push_back(trk_bytes[i]);
        trk_bytes.delete();
    endfunction

    function automatic void chan_msg(ref logic [7:0] last_st, input logic [7:0] st,
                                     input logic [7:0] d1, input logic [7:0] d2, input bit two);
        if (st != last_st || $urandom_range(0, 2) == 0) trk_bytes.push_back(st);
        trk_bytes.push_back(d1);
        if (two) trk_bytes.push_back(d2);
        last_st = st;
    endfunction

    function automatic void build_track(int n_events);
        logic [7:0] last_st;
        logic [3:0] ch;
        logic [7:0] key, vel;
        int r, n;
        last_st = '0;
        repeat (n_events) begin
            r = $urandom_range(0, 99);
            put_var(($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 200));
            ch = 4'($urandom_range(0, 1));
            key = 8'($urandom_range(60, 63)) | (($urandom_range(0, 15) == 0) ? 8'h80 : 8'h00);
            vel = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            if (r < 45) chan_msg(last_st, {4'h9, ch}, key, vel, 1);
            else if (r < 72) chan_msg(last_st, {4'h8, ch}, key, 8'($urandom_range(0, 127)), 1);
            else if (r < 78) chan_msg(last_st, {4'hC, ch}, 8'($urandom_range(0, 127)), 0, 0);
            else if (r < 82) chan_msg(last_st, {4'hE, ch}, 8'($urandom), 8'($urandom), 1);
            else if (r < 88) begin
                n = $urandom_range(2, 4);
                trk_bytes.push_back(8'hFF); trk_bytes.push_back(8'h51); put_var(n);
                repeat (n) trk_bytes.push_back(8'($urandom));
                last_st = '0;
            end else begin
                n = $urandom_range(0, 5);
                trk_bytes.push_back(($urandom_range(0, 1) != 0) ? 8'hF0 :
                                    ((r < 94) ? 8'hF7 : 8'hFF));
                if (trk_bytes[$] == 8'hFF) trk_bytes.push_back(8'($urandom_range(1, 127)));
                put_var(n);
                repeat (n) trk_bytes.push_back(8'($urandom));
                last_st = '0;
            end
        end
        put_var(0);
        trk_bytes.push_back(8'hFF); trk_bytes.push_back(8'h2F); trk_bytes.push_back(8'h00);
    endfunction

    task automatic random_file();
        int ntrk, actual, r, cut;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            // bare noise with random restart and end flags
            repeat ($urandom_range(4, 16))
                send_byte(8'($urandom), $urandom_range(0, 4) == 0, $urandom_range(0, 7) == 0);
            return;
        end
        actual = $urandom_range(1, 3);
        ntrk = (r < 20) ? $urandom_range(0, 4) : actual;
        put_header(16'(ntrk), ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(24, 960)),
                   ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : 0);
        repeat (actual) begin
            build_track($urandom_range(3, 12));
            put_track(($urandom_range(0, 9) == 0) ? 32'($urandom_range(0, trk_bytes.size()))
                                                  : 32'(trk_bytes.size()));
        end
        if (r >= 20 && r < 28) begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > cut) void'(file_bytes.pop_back());
        end else if (r >= 28 && r < 34) begin
            file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
        end
        play_file();
    endtask

    // ---------------- tests ----------------
    task automatic test_error_codes();
        // bad chunk tag
        file_bytes = '{8'h4D, 8'h54, 8'h68, 8'h65, 8'h00};
        play_file();
        // header with no tracks
        put_header(16'd0, 16'd480, 0);
        play_file();
        // data byte with no running status
        put_header(16'd1, 16'd96, 0);
        trk_bytes = '{8'h00, 8'h40, 8'h40};
        put_track(32'd3);
        play_file();
        // undefined status byte
        put_header(16'd1, 16'd96, 0);
        trk_bytes = '{8'h00, 8'hF1};
        put_track(32'd2);
        play_file();
        // data byte after a meta event left running status on 0xff
        put_header(16'd1, 16'd96, 0);
        trk_bytes = '{8'h00, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h40};
        put_track(32'd6);
        play_file();
        // file cut short
        put_header(16'd2, 16'd96, 0);
        play_file();
    endtask

    task automatic test_note_pairing();
        put_header(16'd3, 16'd0, 2);
        put_track(32'd0);           // empty track ends at once
        trk_bytes = '{8'h00, 8'h90, 8'h3C, 8'h40, 8'h00, 8'h90, 8'h3C, 8'h50,
                      8'h83, 8'h60, 8'h80, 8'h3C, 8'h00, 8'h00, 8'h3C, 8'h00,
                      8'h00, 8'h91, 8'hBC, 8'h40,
                      8'h8F, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h91, 8'h3C, 8'h00,
                      8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'h00, 8'h00,
                      8'h00, 8'h90, 8'h10, 8'h40, 8'h10, 8'h80, 8'h10, 8'h00,
                      8'h00, 8'hFF, 8'h51, 8'h02, 8'h11, 8'h22,
                      8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, 8'h9F, 8'h7F, 8'h7F, 8'h05, 8'h8F, 8'h7F, 8'h00,
                      8'h00, 8'hFF, 8'h2F, 8'h00};
        put_track(32'(trk_bytes.size()));
        // meta body runs past the declared end of the chunk
        trk_bytes = '{8'h00, 8'hFF, 8'h51, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'h55};
        put_track(32'd5);
        play_file();
    endtask

    task automatic test_random_traffic(int idle_src, int idle_snk, int n_bytes);
        int stop_at;
        src_idle = idle_src; snk_idle = idle_snk;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) random_file();
        wait_drained();
    endtask

    task automatic test_backpressure();
        src_idle = 0; snk_idle = 0;
        hold_cycles = 4000;
        repeat (3) random_file();
        wait_drained();
    endtask

    initial begin
        in_ch.valid = 1'b0; in_ch.file_byte = '0; in_ch.first_byte = 1'b0;
        in_ch.last_byte = 1'b0; out_ch.ready = 1'b0;
        sample_rate = SAMPLE_RATE_RESET;
        restart_parse();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        test_error_codes();
        test_note_pairing();
        wait_drained();
        write_sample_rate(20'd1000000);
        test_note_pairing();
        wait_drained();
        write_sample_rate(20'd1);
        test_note_pairing();
        wait_drained();
        write_sample_rate(20'($urandom_range(8000, 192000)));
        test_random_traffic(34, 81, 170);
        write_sample_rate(20'd1000000);
        test_random_traffic(81, 34, 170);
        write_sample_rate(SAMPLE_RATE_RESET);
        test_random_traffic(0, 0, 170);
        test_backpressure();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/mfne_pkg.sv
rtl/core/mfne_in_if.sv
rtl/core/mfne_out_if.sv
rtl/core/mfne_conv.sv
rtl/core/mfne_datapath.sv
rtl/core/mfne_ctrl.sv
rtl/core/midi_file_note_extractor_unit.sv
tb/tb_top.sv
